@@ rtl/core/ekd_pkg.sv @@
package ekd_pkg;

  localparam int unsigned MaxTextLenDefault = 32;

  localparam logic [7:0] ChEsc       = 8'd27;
  localparam logic [7:0] ChLBracket  = 8'd91;
  localparam logic [7:0] ChBackquote = 8'h60;
  localparam logic [7:0] ChTilde     = 8'h7E;
  localparam logic [7:0] ChDel       = 8'd127;
  localparam logic [7:0] ChBs        = 8'd8;
  localparam logic [7:0] ChLf        = 8'd10;
  localparam logic [7:0] ChCr        = 8'd13;
  localparam logic [7:0] ChSpace     = 8'd32;
  localparam logic [7:0] ChUp        = 8'h41;
  localparam logic [7:0] ChDown      = 8'h42;
  localparam logic [7:0] ChRight     = 8'h43;
  localparam logic [7:0] ChLeft      = 8'h44;
  localparam logic [7:0] ChInsert    = 8'h32;
  localparam logic [7:0] ChHome      = 8'h31;
  localparam logic [7:0] ChPageUp    = 8'h35;

  typedef enum logic [3:0] {
    KC_NONE    = 4'd0,
    KC_RIGHT   = 4'd1,
    KC_LEFT    = 4'd2,
    KC_UP      = 4'd3,
    KC_DOWN    = 4'd4,
    KC_SHIFT_L = 4'd5,
    KC_ENTER   = 4'd6,
    KC_SHIFT_R = 4'd7,
    KC_TYPED   = 4'd8,
    KC_QUIT    = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    PS_IDLE  = 2'd0,
    PS_ESC   = 2'd1,
    PS_CSI   = 2'd2,
    PS_TILDE = 2'd3
  } parse_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RESULT = 2'd1,
    ST_READ   = 2'd2,
    ST_STREAM = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic stream_start;
    logic stream_last;
  } dp_stat_t;

  function automatic logic is_backspace(logic [7:0] c);
    return (c == ChBs) || (c == ChDel);
  endfunction

  function automatic logic is_text(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == ChSpace) || is_backspace(c);
  endfunction

endpackage

@@ rtl/core/ekd_in_if.sv @@
interface ekd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

@@ rtl/core/ekd_out_if.sv @@
interface ekd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] text_char;
  logic       text_valid;
  logic [5:0] text_length;
  logic       last;

  modport source (output valid, command, text_char, text_valid, text_length, last,
                  input ready);
  modport sink (input valid, command, text_char, text_valid, text_length, last,
                output ready);
endinterface

@@ rtl/core/ekd_ctrl.sv @@
module ekd_ctrl
  import ekd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.stream_start ? ST_READ : ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_STREAM;
      end
      ST_STREAM: begin
        if (out_ready_i) begin
          state_d = stat_i.stream_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RESULT: begin
        out_valid_o = 1'b1;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_STREAM: begin
        out_valid_o = 1'b1;
        cmd_o.step  = out_ready_i && !stat_i.stream_last;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_STREAM)
    else $error("read not followed by stream word");

endmodule

@@ rtl/core/ekd_datapath.sv @@
module ekd_datapath
  import ekd_pkg::*;
#(
  parameter int unsigned MAX_TEXT_LEN = MaxTextLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  output logic [3:0] command_o,
  output logic [7:0] text_char_o,
  output logic       text_valid_o,
  output logic [5:0] text_length_o,
  output logic       last_o
);

  localparam int unsigned CW = $clog2(MAX_TEXT_LEN + 1);
  localparam int unsigned AW = (MAX_TEXT_LEN > 1) ? $clog2(MAX_TEXT_LEN) : 1;

  parse_e         ps_q, ps_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  idx_q;
  logic           stream_q;
  cmd_e           res_cmd_q, cmd_d;
  logic [7:0]     rd_q;
  logic [7:0]     mem_q [MAX_TEXT_LEN];
  logic           plain;
  logic           wr_en;

  always_comb begin
    ps_d    = ps_q;
    cmd_d   = KC_NONE;
    plain   = 1'b0;
    count_d = count_q;
    wr_en   = 1'b0;
    if (action_i) begin
      count_d = '0;
    end else if (rx_byte_i == ChBackquote) begin
      cmd_d = KC_QUIT;
    end else begin
      unique case (ps_q)
        PS_IDLE: begin
          if (rx_byte_i == ChEsc) ps_d = PS_ESC;
          else plain = 1'b1;
        end
        PS_ESC: begin
          if (rx_byte_i == ChLBracket) begin
            ps_d = PS_CSI;
          end else begin
            ps_d  = PS_IDLE;
            plain = 1'b1;
          end
        end
        PS_CSI: begin
          ps_d = PS_IDLE;
          unique case (rx_byte_i)
            ChUp:     cmd_d = KC_UP;
            ChDown:   cmd_d = KC_DOWN;
            ChRight:  cmd_d = KC_RIGHT;
            ChLeft:   cmd_d = KC_LEFT;
            ChInsert: begin
              cmd_d = KC_SHIFT_L;
              ps_d  = PS_TILDE;
            end
            ChHome: begin
              cmd_d = KC_ENTER;
              ps_d  = PS_TILDE;
            end
            ChPageUp: begin
              cmd_d = KC_SHIFT_R;
              ps_d  = PS_TILDE;
            end
            default:  plain = 1'b1;
          endcase
        end
        PS_TILDE: begin
          ps_d  = PS_IDLE;
          plain = (rx_byte_i != ChTilde);
        end
        default: ps_d = PS_IDLE;
      endcase
      if (plain) begin
        if (is_text(rx_byte_i)) begin
          if (is_backspace(rx_byte_i)) begin
            if (count_q != '0) count_d = count_q - CW'(1);
          end else if (count_q < CW'(MAX_TEXT_LEN)) begin
            count_d = count_q + CW'(1);
            wr_en   = 1'b1;
          end
        end else if (rx_byte_i == ChLf || rx_byte_i == ChCr) begin
          cmd_d = KC_TYPED;
        end
      end
    end
  end

  assign stat_o.stream_start = (cmd_d == KC_TYPED) && (count_q != '0);
  assign stat_o.stream_last  = (CW'(idx_q) + CW'(1)) == count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q     <= PS_IDLE;
      count_q  <= '0;
      stream_q <= 1'b0;
      idx_q    <= '0;
    end else if (cmd_i.load) begin
      ps_q     <= ps_d;
      count_q  <= count_d;
      stream_q <= stat_o.stream_start;
      idx_q    <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_en) begin
      mem_q[count_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[idx_q];
    end
  end

  assign command_o     = stream_q ? KC_TYPED : res_cmd_q;
  assign text_char_o   = stream_q ? rd_q : 8'd0;
  assign text_valid_o  = stream_q;
  assign text_length_o = 6'(count_q);
  assign last_o        = stream_q ? stat_o.stream_last : 1'b1;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TEXT_LEN))
    else $error("text count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> stream_q && count_q != '0)
    else $error("buffer read outside a stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> stream_q && idx_q == $past(idx_q) + AW'(1))
    else $error("stream index did not advance");

endmodule

@@ rtl/core/escape_key_decoder_line_editor_unit.sv @@
// Channel  Dir  Word fields                                          Handshake
// in_i     in   action, rx_byte                                      valid/ready
// out_o    out  command, text_char, text_valid, text_length, last    valid/ready
//
// An ordinary byte or a clear is accepted, then gives one result word.
// A line end with N buffered characters (N > 0) gives N result words: each
// word is read on the buffer memory's registered read port, then shown.
// One word is handled at a time; in_i.ready is low until its last result leaves.
// Output stalls hold the result word; rst_ni clears parser state and text count.
module escape_key_decoder_line_editor_unit
  import ekd_pkg::*;
#(
  parameter int unsigned MAX_TEXT_LEN = MaxTextLenDefault
) (
  input logic clk_i,
  input logic rst_ni,
  ekd_in_if.sink    in_i,
  ekd_out_if.source out_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ekd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  ekd_datapath #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .action_i      (in_i.action),
    .rx_byte_i     (in_i.rx_byte),
    .command_o     (out_o.command),
    .text_char_o   (out_o.text_char),
    .text_valid_o  (out_o.text_valid),
    .text_length_o (out_o.text_length),
    .last_o        (out_o.last)
  );

endmodule
